@@ src/imrs_pkg.sv @@
// ----------------------------------------------------------------------------
// imrs_pkg
// Shared types and constants for the IMU motion rate selector.
// ----------------------------------------------------------------------------
package imrs_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_WINDOW_DEPTH = 64;
  localparam int DEF_NORM_SPAN    = 20;

  // Field widths
  localparam int AXIS_W   = 16;
  localparam int N_AXES   = 6;
  localparam int SAMPLE_W = AXIS_W * N_AXES;
  localparam int NORM_W   = 16;
  localparam int LEVEL_W  = 17;
  localparam int RATE_W   = 16;
  localparam int VAR_W    = 31;

  // Window fill thresholds and level saturation
  localparam int STILL_MIN_FILL  = 20;
  localparam int MOTION_MIN_FILL = 10;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;

  // Serial divider: quotient widths of the two divisions
  localparam int DIV_QW = 31;
  localparam int DIV_CW = 5;
  localparam logic [DIV_CW-1:0] VAR_QBITS = 5'd31;
  localparam logic [DIV_CW-1:0] LVL_QBITS = 5'd17;

  // Divider request
  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] qbits;
  } div_req_t;

  // Configuration register map (word index)
  typedef enum logic [2:0] {
    REG_ADAPTIVE_EN = 3'd0,
    REG_BASE_RATE   = 3'd1,
    REG_STAT_RATE   = 3'd2,
    REG_MOVE_RATE   = 3'd3,
    REG_AGGR_RATE   = 3'd4,
    REG_ACCEL_LIM   = 3'd5,
    REG_GYRO_LIM    = 3'd6,
    REG_MOT_SCALE   = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic        RST_ADAPTIVE_EN = 1'b1;
  localparam logic [15:0] RST_BASE_RATE   = 16'd1600;
  localparam logic [15:0] RST_STAT_RATE   = 16'd160;
  localparam logic [15:0] RST_MOVE_RATE   = 16'd1600;
  localparam logic [15:0] RST_AGGR_RATE   = 16'd3200;
  localparam logic [31:0] RST_ACCEL_LIM   = 32'd1000;
  localparam logic [31:0] RST_GYRO_LIM    = 32'd1000;
  localparam logic [23:0] RST_MOT_SCALE   = 24'd4096;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ src/imu_motion_rate_selector.sv @@
// ----------------------------------------------------------------------------
// imu_motion_rate_selector
// Sliding-window stillness test, gyro motion level and rate selection.
//
//  port group | dir | request contents
//  in_*       | in  | tdata[95:0] = accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
//  out_*      | out | tdata = stationary, motion_level, rate, window_fill, zero pad
//  cfg_*      | in  | APB register write/read, 8 words at byte address 4*i
//
// One sample at a time. Each request passes the 12 square-and-accumulate steps
// and the 16-step square root; with 20 or more held samples the serial divider
// then forms each axis variance, and with 10 or more it forms the level, a
// division that is skipped when the level saturates.
// Reset clears fill count and running sums; window RAM read data is never used
// before written, so no clearing pass is needed. The next request is taken
// while a result still waits in the output register; the last step waits
// only if that register is still full.
// ----------------------------------------------------------------------------
module imu_motion_rate_selector
  import imrs_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int NORM_SPAN    = DEF_NORM_SPAN
) (
  input  logic        clk,
  input  logic        rst_n,
  // Sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // stationary, motion_level[16:0], rate[15:0], window_fill, zero pad
  output logic [((34+$clog2(WINDOW_DEPTH+1)+7)/8)*8-1:0] out_tdata,
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int FW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SPAN  = (NORM_SPAN < WINDOW_DEPTH) ? NORM_SPAN : WINDOW_DEPTH;
  localparam int SUMW  = AXIS_W + 1 + AW;
  localparam int SQW   = 2 * AXIS_W - 1 + AW;
  localparam int RSW   = NORM_W + $clog2(SPAN + 1);
  localparam int CDW   = $clog2(SPAN + 1) + 8;
  localparam int PRW   = RSW + 24;
  localparam int DW    = imax(imax(FW + SQW, 2 * FW + VAR_W),
                              imax(imax(PRW, CDW + LEVEL_W), 2 * SUMW));
  localparam int OUT_DW = 1 + LEVEL_W + RATE_W + FW;
  localparam int OUT_TW = ((OUT_DW + 7) / 8) * 8;
  localparam logic [FW-1:0] FULL_N  = FW'(WINDOW_DEPTH);
  localparam logic [FW-1:0] SPAN_N  = FW'(SPAN);
  localparam logic [AW-1:0] LAST_WP = AW'(WINDOW_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SQ, S_ACC, S_SQRT, S_WR, S_VM, S_VD, S_VDIV, S_VS, S_VA,
    S_LM, S_LD, S_LDIV, S_RATE, S_OUT
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        adaptive_r;
  logic [15:0] base_rate_r, stat_rate_r, move_rate_r, aggr_rate_r;
  logic [31:0] accel_lim_r, gyro_lim_r;
  logic [23:0] mot_scale_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adaptive_r  <= RST_ADAPTIVE_EN;
      base_rate_r <= RST_BASE_RATE;
      stat_rate_r <= RST_STAT_RATE;
      move_rate_r <= RST_MOVE_RATE;
      aggr_rate_r <= RST_AGGR_RATE;
      accel_lim_r <= RST_ACCEL_LIM;
      gyro_lim_r  <= RST_GYRO_LIM;
      mot_scale_r <= RST_MOT_SCALE;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_paddr[4:2]))
        REG_ADAPTIVE_EN: adaptive_r  <= cfg_pwdata[0];
        REG_BASE_RATE:   base_rate_r <= cfg_pwdata[15:0];
        REG_STAT_RATE:   stat_rate_r <= cfg_pwdata[15:0];
        REG_MOVE_RATE:   move_rate_r <= cfg_pwdata[15:0];
        REG_AGGR_RATE:   aggr_rate_r <= cfg_pwdata[15:0];
        REG_ACCEL_LIM:   accel_lim_r <= cfg_pwdata;
        REG_GYRO_LIM:    gyro_lim_r  <= cfg_pwdata;
        REG_MOT_SCALE:   mot_scale_r <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx_t'(cfg_paddr[4:2]))
      REG_ADAPTIVE_EN: cfg_prdata = {31'd0, adaptive_r};
      REG_BASE_RATE:   cfg_prdata = {16'd0, base_rate_r};
      REG_STAT_RATE:   cfg_prdata = {16'd0, stat_rate_r};
      REG_MOVE_RATE:   cfg_prdata = {16'd0, move_rate_r};
      REG_AGGR_RATE:   cfg_prdata = {16'd0, aggr_rate_r};
      REG_ACCEL_LIM:   cfg_prdata = accel_lim_r;
      REG_GYRO_LIM:    cfg_prdata = gyro_lim_r;
      REG_MOT_SCALE:   cfg_prdata = {8'd0, mot_scale_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                state_r;
  logic [AW-1:0]         wp_r;
  logic [FW-1:0]         fill_r;
  logic signed [SUMW-1:0] sum_r [N_AXES];
  logic [SQW-1:0]        sumsq_r [N_AXES];
  logic [RSW-1:0]        rsum_r;
  logic [SAMPLE_W-1:0]   v_r, old_r;
  logic [3:0]            k_r;
  logic [2:0]            j_r;
  logic [31:0]           sq_r, gsq_r, sq_res_r, sq_bit_r;
  logic [FW+SQW-1:0]     vprod_r;
  logic [2*SUMW-1:0]     msq_r;
  logic [2*FW-1:0]       nsq_r;
  logic [2*VAR_W-1:0]    vsq_r;
  logic [63:0]           lsq_r, acc_r;
  logic                  ok_a_r, ok_g_r;
  logic [PRW-1:0]        lprod_r;
  logic [CDW-1:0]        lden_r;
  logic [LEVEL_W-1:0]    level_r;
  logic signed [34:0]    t_r;
  logic                  out_valid_r;
  logic [OUT_DW-1:0]     out_data_r;

  // RAM ports
  logic [SAMPLE_W-1:0] smp_rdata;
  logic [NORM_W-1:0]   nrm_rdata;
  logic [AW-1:0]       nrm_raddr;
  logic                ram_we;
  logic                in_acc;

  // Divider
  div_req_t          div_req;
  logic [DW-1:0]     div_num, div_den;
  logic              div_done;
  logic [DIV_QW-1:0] div_q;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign ram_we     = (state_r == S_WR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'(out_data_r);

  // Oldest sample still inside the norm span
  assign nrm_raddr = (wp_r >= AW'(SPAN)) ? (wp_r - AW'(SPAN))
                                         : AW'(wp_r + AW'(WINDOW_DEPTH - SPAN));

  imrs_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_smp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (v_r),
    .re    (in_acc),
    .raddr (wp_r),
    .rdata (smp_rdata)
  );

  imrs_ram #(.WIDTH(NORM_W), .DEPTH(WINDOW_DEPTH)) u_nrm_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (sq_res_r[NORM_W-1:0]),
    .re    (in_acc),
    .raddr (nrm_raddr),
    .rdata (nrm_rdata)
  );

  imrs_div #(.DW(DW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .num    (div_num),
    .den_sh (div_den),
    .done   (div_done),
    .quot   (div_q)
  );

  // --------------------------------------------------------------------------
  // Datapath combinational helpers
  // --------------------------------------------------------------------------
  logic [2:0]               ax;
  logic signed [AXIS_W-1:0] sq_op;
  logic [32:0]              sq_try;
  logic [FW-1:0]            fill_nxt;
  logic [SUMW-1:0]          ms;
  logic [63:0]              acc_nxt;
  logic [FW-1:0]            cnt_c;
  logic signed [16:0]       rdiff;
  logic signed [19:0]       rate_raw;
  logic signed [19:0]       rate_lo;
  logic [RATE_W-1:0]        rate_sel;
  logic                     still;

  assign ax       = (k_r < 4'd6) ? k_r[2:0] : 3'(k_r - 4'd6);
  assign sq_op    = (k_r < 4'd6) ? old_r[ax*AXIS_W +: AXIS_W] : v_r[ax*AXIS_W +: AXIS_W];
  assign sq_try   = {1'b0, sq_res_r} + {1'b0, sq_bit_r};
  assign fill_nxt = (fill_r < FULL_N) ? fill_r + 1'b1 : fill_r;
  assign ms       = (sum_r[j_r] < 0) ? SUMW'(-sum_r[j_r]) : SUMW'(sum_r[j_r]);
  assign acc_nxt  = acc_r + 64'(vsq_r);
  assign cnt_c    = (fill_r < SPAN_N) ? fill_r : SPAN_N;
  assign rdiff    = $signed({1'b0, aggr_rate_r}) - $signed({1'b0, move_rate_r});
  assign still    = (fill_r < FW'(STILL_MIN_FILL)) || (ok_a_r && ok_g_r);

  // Base rate if not adaptive, stat rate if still, else interpolated floor(t/65536) clamped
  always_comb begin
    rate_raw = $signed({4'd0, move_rate_r}) + 20'($signed(t_r[34:16]));
    rate_lo  = (rate_raw < $signed({4'd0, stat_rate_r})) ? $signed({4'd0, stat_rate_r})
                                                         : rate_raw;
    if (!adaptive_r) begin
      rate_sel = base_rate_r;
    end else if (still) begin
      rate_sel = stat_rate_r;
    end else if (rate_lo > $signed({4'd0, aggr_rate_r})) begin
      rate_sel = aggr_rate_r;
    end else begin
      rate_sel = rate_lo[15:0];
    end
  end

  // Divider request
  always_comb begin
    div_req.start = 1'b0;
    div_req.qbits = VAR_QBITS;
    div_num       = DW'(vprod_r) - DW'(msq_r);
    div_den       = DW'(nsq_r) << (VAR_W - 1);
    if (state_r == S_VD) begin
      div_req.start = 1'b1;
    end else if (state_r == S_LD) begin
      div_req.start = (DW'(lprod_r) < (DW'(lden_r) << LEVEL_W));
      div_req.qbits = LVL_QBITS;
      div_num       = DW'(lprod_r);
      div_den       = DW'(lden_r) << (LEVEL_W - 1);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      rsum_r      <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      for (int a = 0; a < N_AXES; a++) begin
        sum_r[a]   <= '0;
        sumsq_r[a] <= '0;
      end
    end else begin
      // Output register drains; S_OUT refills it itself
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        // Take a sample, RAM reads go out on the same edge
        S_IDLE: begin
          if (in_acc) begin
            v_r     <= in_tdata;
            gsq_r   <= '0;
            state_r <= S_RD;
          end
        end
        // Old sample and old norm arrive
        S_RD: begin
          old_r <= smp_rdata;
          if (fill_r >= SPAN_N) begin
            rsum_r <= rsum_r - RSW'(nrm_rdata);
          end
          k_r     <= '0;
          state_r <= S_SQ;
        end
        // Square one axis value: old ones first, then new ones
        S_SQ: begin
          sq_r    <= 32'(sq_op * sq_op);
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (k_r < 4'd6) begin
            if (fill_r >= FULL_N) begin
              sum_r[ax]   <= sum_r[ax] - SUMW'(sq_op);
              sumsq_r[ax] <= sumsq_r[ax] - SQW'(sq_r);
            end
          end else begin
            sum_r[ax]   <= sum_r[ax] + SUMW'(sq_op);
            sumsq_r[ax] <= sumsq_r[ax] + SQW'(sq_r);
            if (k_r >= 4'd9) begin
              gsq_r <= gsq_r + sq_r;
            end
          end
          k_r <= k_r + 1'b1;
          if (k_r == 4'd11) begin
            sq_res_r <= '0;
            sq_bit_r <= 32'h4000_0000;
            state_r  <= S_SQRT;
          end else begin
            state_r <= S_SQ;
          end
        end
        // Floor of the gyro magnitude (square root of the sum of squares), two bits per step
        S_SQRT: begin
          if ({1'b0, gsq_r} >= sq_try) begin
            gsq_r    <= gsq_r - sq_try[31:0];
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r[0]) begin
            state_r <= S_WR;
          end
        end
        // Write back sample and norm, advance the window
        S_WR: begin
          rsum_r  <= rsum_r + RSW'(sq_res_r[NORM_W-1:0]);
          wp_r    <= (wp_r == LAST_WP) ? '0 : wp_r + 1'b1;
          fill_r  <= fill_nxt;
          j_r     <= '0;
          acc_r   <= '0;
          state_r <= (fill_nxt >= FW'(STILL_MIN_FILL)) ? S_VM : S_LM;
        end
        // Variance of axis j: numerator and denominator terms
        S_VM: begin
          vprod_r <= fill_r * sumsq_r[j_r];
          msq_r   <= ms * ms;
          nsq_r   <= fill_r * fill_r;
          state_r <= S_VD;
        end
        S_VD: begin
          state_r <= S_VDIV;
        end
        S_VDIV: begin
          if (div_done) begin
            state_r <= S_VS;
          end
        end
        S_VS: begin
          vsq_r   <= div_q * div_q;
          lsq_r   <= (j_r < 3'd3) ? accel_lim_r * accel_lim_r : gyro_lim_r * gyro_lim_r;
          state_r <= S_VA;
        end
        S_VA: begin
          acc_r <= acc_nxt;
          if (j_r == 3'd2) begin
            ok_a_r <= (acc_nxt < lsq_r);
            acc_r  <= '0;
          end
          if (j_r == 3'd5) begin
            ok_g_r  <= (acc_nxt < lsq_r);
            state_r <= S_LM;
          end else begin
            state_r <= S_VM;
          end
          j_r <= j_r + 1'b1;
        end
        // Motion level: mean norm times scale over c*256
        S_LM: begin
          lprod_r <= rsum_r * mot_scale_r;
          lden_r  <= CDW'({cnt_c, 8'd0});
          level_r <= '0;
          state_r <= (fill_r < FW'(MOTION_MIN_FILL)) ? S_RATE : S_LD;
        end
        S_LD: begin
          level_r <= LEVEL_ONE;
          state_r <= div_req.start ? S_LDIV : S_RATE;
        end
        S_LDIV: begin
          if (div_done) begin
            level_r <= (div_q[LEVEL_W-1:0] > LEVEL_ONE) ? LEVEL_ONE : div_q[LEVEL_W-1:0];
            state_r <= S_RATE;
          end
        end
        S_RATE: begin
          t_r     <= rdiff * $signed({1'b0, level_r});
          state_r <= S_OUT;
        end
        // Hand the result to the output register
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {fill_r, rate_sel, level_r, still};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_RD)
    else $error("accepted request did not start a RAM read cycle");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_done)
    else $error("divider restarted while busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_N)
    else $error("window fill beyond depth");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_data_r[OUT_DW-1 -: FW] == fill_r)
    else $error("reported fill differs from window fill");
`endif

endmodule

@@ src/imrs_ram.sv @@
// ----------------------------------------------------------------------------
// imrs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/imrs_div.sv @@
// ----------------------------------------------------------------------------
// imrs_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imrs_div
  import imrs_pkg::*;
#(
  parameter int DW = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  input  logic [DW-1:0]     num,
  input  logic [DW-1:0]     den_sh,   // divisor pre-shifted by qbits-1
  output logic              done,
  output logic [DIV_QW-1:0] quot
);

  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     dsh_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_QW-1:0] q_r;
  logic              fit;

  assign fit  = (rem_r >= dsh_r);
  assign done = (cnt_r == '0);
  assign quot = q_r;

  // Control count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= req.qbits;
    end else if (!done) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Datapath: one compare and subtract per step
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= num;
      dsh_r <= den_sh;
      q_r   <= '0;
    end else if (!done) begin
      if (fit) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[DIV_QW-2:0], fit};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule
